>>> src/pli_pkg.sv
package pli_pkg;

    // Fixed-point format of hue, saturation and lightness
    localparam int FRAC_BITS = 16;
    localparam int ONE_W     = FRAC_BITS + 1;
    localparam logic [ONE_W-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ONE_W-1:0] THIRD = ONE_W'((2 ** FRAC_BITS) / 3);

    // Offset register is a 16-bit fraction; align it to FRAC_BITS
    localparam int OFS_UP = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int OFS_DN = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);
    localparam int OFS_W  = FRAC_BITS + 16;

    // Divider: remainder and divisor width (divisor up to 6*255), one quotient bit per stage
    localparam int DIV_W     = 11;
    localparam int DIV_STEPS = FRAC_BITS + 1;

    // Cycles from accepted request to sampled result strobe
    localparam int LATENCY = DIV_STEPS + 6;

    // Configuration port
    localparam int PADDR_W  = 5;
    localparam int REG_ID_W = 3;
    localparam logic [REG_ID_W-1:0] REG_THRESH = 3'd0;
    localparam logic [REG_ID_W-1:0] REG_BG_RED = 3'd1;
    localparam logic [REG_ID_W-1:0] REG_BG_GRN = 3'd2;
    localparam logic [REG_ID_W-1:0] REG_BG_BLU = 3'd3;
    localparam logic [REG_ID_W-1:0] REG_OFFSET = 3'd4;

    localparam logic [7:0]  RST_THRESH = 8'd240;
    localparam logic [7:0]  RST_BG     = 8'd32;
    localparam logic [15:0] RST_OFFSET = 16'd8192;

    // Front stage result: operands for both dividers plus sideband
    typedef struct packed {
        logic             valid;
        logic             replaced;
        logic             gray;
        logic [7:0]       alpha;
        logic [8:0]       sum;
        logic [DIV_W-1:0] s_rem;
        logic             s_lsb;
        logic [DIV_W-1:0] s_den;
        logic [DIV_W-1:0] h_rem;
        logic             h_lsb;
        logic [DIV_W-1:0] h_den;
    } t_front;

    // Sideband that travels beside the dividers; light holds L, then new L
    typedef struct packed {
        logic             valid;
        logic             replaced;
        logic             gray;
        logic [7:0]       alpha;
        logic [ONE_W-1:0] light;
    } t_side;

endpackage

>>> src/pli_front.sv
module pli_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_alpha,
    input  logic [7:0]         i_thresh,
    output pli_pkg::t_front    o_front
);

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [8:0]  sum;
    logic [11:0] d12;
    logic [11:0] num;
    logic [11:0] h_den;
    logic [8:0]  s_den;
    pli_pkg::t_front n_front;
    pli_pkg::t_front r_front;

    // Find extremes, hue numerator and saturation divisor
    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        d12 = {4'd0, d};

        if (mx == i_red) begin
            if (i_green >= i_blue) num = {4'd0, i_green} - {4'd0, i_blue};
            else num = (d12 * 12'd6) - ({4'd0, i_blue} - {4'd0, i_green});
        end else if (mx == i_green) begin
            num = (d12 << 1) + {4'd0, i_blue} - {4'd0, i_red};
        end else begin
            num = (d12 << 2) + {4'd0, i_red} - {4'd0, i_green};
        end

        h_den = d12 * 12'd6;
        s_den = (sum > 9'd255) ? (9'd510 - sum) : sum;

        n_front.valid    = i_valid;
        n_front.replaced = (i_red >= i_thresh) && (i_green >= i_thresh)
                           && (i_blue >= i_thresh);
        n_front.gray     = (d == 8'd0);
        n_front.alpha    = i_alpha;
        n_front.sum      = sum;
        n_front.s_rem    = pli_pkg::DIV_W'(d >> 1);
        n_front.s_lsb    = d[0];
        n_front.s_den    = pli_pkg::DIV_W'(s_den);
        n_front.h_rem    = pli_pkg::DIV_W'(num >> 1);
        n_front.h_lsb    = num[0];
        n_front.h_den    = h_den[pli_pkg::DIV_W-1:0];
        // Gray pixel: keep dividers away from a zero divisor
        if (d == 8'd0) begin
            n_front.s_rem = '0;
            n_front.s_lsb = 1'b0;
            n_front.s_den = pli_pkg::DIV_W'(1);
            n_front.h_rem = '0;
            n_front.h_lsb = 1'b0;
            n_front.h_den = pli_pkg::DIV_W'(1);
        end
    end

    // Hold valid under reset, advance payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else begin
            r_front.valid <= n_front.valid;
        end
        r_front.replaced <= n_front.replaced;
        r_front.gray     <= n_front.gray;
        r_front.alpha    <= n_front.alpha;
        r_front.sum      <= n_front.sum;
        r_front.s_rem    <= n_front.s_rem;
        r_front.s_lsb    <= n_front.s_lsb;
        r_front.s_den    <= n_front.s_den;
        r_front.h_rem    <= n_front.h_rem;
        r_front.h_lsb    <= n_front.h_lsb;
        r_front.h_den    <= n_front.h_den;
    end

    assign o_front = r_front;

endmodule

>>> src/pli_div.sv
module pli_div (
    input  logic                            i_clk,
    input  logic [pli_pkg::DIV_W-1:0]       i_rem,
    input  logic                            i_lsb,
    input  logic [pli_pkg::DIV_W-1:0]       i_den,
    output logic [pli_pkg::DIV_STEPS-1:0]   o_quo
);

    logic [pli_pkg::DIV_W-1:0]     r_rem [pli_pkg::DIV_STEPS];
    logic [pli_pkg::DIV_W-1:0]     r_den [pli_pkg::DIV_STEPS];
    logic [pli_pkg::DIV_STEPS-1:0] r_quo [pli_pkg::DIV_STEPS];

    // One restoring step per stage: shift in a bit, subtract when it fits
    for (genvar j = 0; j < pli_pkg::DIV_STEPS; j++) begin : g_step
        logic [pli_pkg::DIV_W-1:0]     rem_in;
        logic [pli_pkg::DIV_W-1:0]     den_in;
        logic [pli_pkg::DIV_STEPS-1:0] quo_in;
        logic                          bit_in;
        logic [pli_pkg::DIV_W:0]       trial;
        logic [pli_pkg::DIV_W:0]       diff;
        logic                          fits;
        logic [pli_pkg::DIV_W-1:0]     n_rem;
        logic [pli_pkg::DIV_STEPS-1:0] n_quo;

        if (j == 0) begin : g_first
            assign rem_in = i_rem;
            assign den_in = i_den;
            assign quo_in = '0;
            assign bit_in = i_lsb;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign bit_in = 1'b0;
        end

        always_comb begin
            trial = {rem_in, bit_in};
            diff  = trial - {1'b0, den_in};
            fits  = (trial >= {1'b0, den_in});
            n_rem = fits ? diff[pli_pkg::DIV_W-1:0] : trial[pli_pkg::DIV_W-1:0];
            n_quo = {quo_in[pli_pkg::DIV_STEPS-2:0], fits};
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= n_rem;
            r_den[j] <= den_in;
            r_quo[j] <= n_quo;
        end
    end

    assign o_quo = r_quo[pli_pkg::DIV_STEPS-1];

endmodule

>>> src/pli_back.sv
module pli_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pli_pkg::t_side                  i_side,
    input  logic [pli_pkg::ONE_W-1:0]       i_sat,
    input  logic [pli_pkg::FRAC_BITS-1:0]   i_hue,
    input  logic [7:0]                      i_bg_red,
    input  logic [7:0]                      i_bg_green,
    input  logic [7:0]                      i_bg_blue,
    output logic                            o_valid,
    output logic [7:0]                      o_red,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_blue,
    output logic [7:0]                      o_alpha,
    output logic                            o_replaced
);

    localparam int W  = pli_pkg::ONE_W;
    localparam int FB = pli_pkg::FRAC_BITS;

    // Segment of the hue ramp
    localparam logic [1:0] SEL_RISE = 2'd0;
    localparam logic [1:0] SEL_HIGH = 2'd1;
    localparam logic [1:0] SEL_FALL = 2'd2;
    localparam logic [1:0] SEL_LOW  = 2'd3;

    // Stage 1: nl * S
    logic           r1_valid, r1_replaced, r1_gray;
    logic [7:0]     r1_alpha;
    logic [W-1:0]   r1_nl, r1_sat;
    logic [FB-1:0]  r1_hue;
    logic [2*W-1:0] r1_prod;
    // Stage 2: q, p and channel hues
    logic           r2_valid, r2_replaced, r2_gray;
    logic [7:0]     r2_alpha;
    logic [W-1:0]   r2_nl, r2_q, r2_p, r2_diff;
    logic [W-1:0]   r2_t [3];
    // Stage 3: ramp product per channel
    logic           r3_valid, r3_replaced, r3_gray;
    logic [7:0]     r3_alpha;
    logic [W-1:0]   r3_nl, r3_q, r3_p;
    logic [1:0]     r3_sel [3];
    logic [2*W-1:0] r3_prod [3];
    // Stage 4: channel level
    logic           r4_valid, r4_replaced;
    logic [7:0]     r4_alpha;
    logic [W-1:0]   r4_v [3];
    // Stage 5: output bytes
    logic           r_valid, r_replaced;
    logic [7:0]     r_alpha;
    logic [7:0]     r_byte [3];

    logic [W:0]     qw, pw;
    logic [W-1:0]   ps, q, p, hw, tr;
    logic [W-1:0]   n_t [3];
    logic [1:0]     n_sel [3];
    logic [2*W-1:0] n_prod [3];
    logic [W-1:0]   n_v [3];
    logic [7:0]     n_byte [3];
    logic [7:0]     bg [3];

    // Form q and p, and offset the hue per channel
    always_comb begin
        ps = r1_prod[FB +: W];
        if ({r1_nl, 1'b0} < {1'b0, pli_pkg::ONE}) qw = {1'b0, r1_nl} + {1'b0, ps};
        else qw = {1'b0, r1_nl} + {1'b0, r1_sat} - {1'b0, ps};
        pw = {r1_nl, 1'b0} - qw;
        q  = qw[W-1:0];
        p  = pw[W-1:0];
        hw = {1'b0, r1_hue};
        tr = hw + pli_pkg::THIRD;
        if (tr > pli_pkg::ONE) tr = tr - pli_pkg::ONE;
        n_t[0] = tr;
        n_t[1] = hw;
        n_t[2] = (hw >= pli_pkg::THIRD) ? (hw - pli_pkg::THIRD)
                                         : (hw + pli_pkg::ONE - pli_pkg::THIRD);
    end

    // Pick the ramp segment and scale (q - p)
    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [W+2:0] six;
        logic [W+2:0] fall;
        logic [W+1:0] three;
        logic [W-1:0] factor;

        always_comb begin
            six   = ({2'b0, r2_t[k], 1'b0}) + ({1'b0, r2_t[k], 2'b0});
            three = {r2_t[k], 1'b0} + {2'b0, r2_t[k]};
            fall  = {pli_pkg::ONE, 2'b0} - six;
            if (six < {3'b0, pli_pkg::ONE}) begin
                n_sel[k] = SEL_RISE;
                factor   = six[W-1:0];
            end else if ({r2_t[k], 1'b0} < {1'b0, pli_pkg::ONE}) begin
                n_sel[k] = SEL_HIGH;
                factor   = '0;
            end else if (three < {pli_pkg::ONE, 1'b0}) begin
                n_sel[k] = SEL_FALL;
                factor   = fall[W-1:0];
            end else begin
                n_sel[k] = SEL_LOW;
                factor   = '0;
            end
            n_prod[k] = r2_diff * factor;
        end

        // Resolve level, clamp to one
        logic [W:0] lvl;
        always_comb begin
            case (r3_sel[k])
                SEL_RISE, SEL_FALL: lvl = {1'b0, r3_p} + {1'b0, r3_prod[k][FB +: W]};
                SEL_HIGH:           lvl = {1'b0, r3_q};
                default:            lvl = {1'b0, r3_p};
            endcase
            if (r3_gray) lvl = {1'b0, r3_nl};
            n_v[k] = (lvl > {1'b0, pli_pkg::ONE}) ? pli_pkg::ONE : lvl[W-1:0];
        end

        // Scale to a byte: v * 255 / ONE, or take the background byte when replaced
        logic [W+7:0] scaled;
        always_comb begin
            scaled    = {r4_v[k], 8'd0} - {8'd0, r4_v[k]};
            n_byte[k] = r4_replaced ? bg[k] : scaled[FB +: 8];
        end
    end

    assign bg[0] = i_bg_red;
    assign bg[1] = i_bg_green;
    assign bg[2] = i_bg_blue;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r1_valid <= i_side.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r_valid  <= r4_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r1_replaced <= i_side.replaced;
        r1_gray     <= i_side.gray || (i_sat == '0);
        r1_alpha    <= i_side.alpha;
        r1_nl       <= i_side.light;
        r1_sat      <= i_sat;
        r1_hue      <= i_hue;
        r1_prod     <= i_side.light * i_sat;

        r2_replaced <= r1_replaced;
        r2_gray     <= r1_gray;
        r2_alpha    <= r1_alpha;
        r2_nl       <= r1_nl;
        r2_q        <= q;
        r2_p        <= p;
        r2_diff     <= q - p;

        r3_replaced <= r2_replaced;
        r3_gray     <= r2_gray;
        r3_alpha    <= r2_alpha;
        r3_nl       <= r2_nl;
        r3_q        <= r2_q;
        r3_p        <= r2_p;

        r4_replaced <= r3_replaced;
        r4_alpha    <= r3_alpha;

        r_replaced  <= r4_replaced;
        r_alpha     <= r4_alpha;

        for (int k = 0; k < 3; k++) begin
            r2_t[k]    <= n_t[k];
            r3_sel[k]  <= n_sel[k];
            r3_prod[k] <= n_prod[k];
            r4_v[k]    <= n_v[k];
            r_byte[k]  <= n_byte[k];
        end
    end

    assign o_valid    = r_valid;
    assign o_red      = r_byte[0];
    assign o_green    = r_byte[1];
    assign o_blue     = r_byte[2];
    assign o_alpha    = r_alpha;
    assign o_replaced = r_replaced;

endmodule

>>> src/pixel_lightness_inverter_core.sv
// Pixel lightness inverter: recolors one RGBA pixel per request.
// Request channel: drive start high with the four channel bytes; a request is
// taken at every rising edge with start high, since busy stays low. A new
// pixel may follow in every cycle.
// Result channel: o_valid marks the recolored pixel for exactly one cycle;
// results come out in request order and the receiver must take them as they
// appear (there is no back-pressure).
// Near-white pixels (all channels at or above the threshold) come out as the
// background color with o_was_replaced set; others have their HSL lightness
// inverted and offset. Alpha passes through.
// Throughput is one pixel per cycle. Latency is set by the two quotient
// pipelines for saturation and hue (one quotient bit per stage, 17 stages)
// plus one front stage and five back stages.
// Configuration: APB registers at byte addresses 0 (threshold), 4, 8, 12
// (background red, green, blue) and 16 (lightness offset, 16-bit fraction).
// Write them only while no pixel is in flight.
// Reset (synchronous, active low) clears all in-flight pixels and restores
// threshold 240, background 32/32/32 and offset 0.125.
module pixel_lightness_inverter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [7:0]                  i_pixel_red,
    input  logic [7:0]                  i_pixel_green,
    input  logic [7:0]                  i_pixel_blue,
    input  logic [7:0]                  i_pixel_alpha,
    output logic                        o_valid,
    output logic [7:0]                  o_new_red,
    output logic [7:0]                  o_new_green,
    output logic [7:0]                  o_new_blue,
    output logic [7:0]                  o_new_alpha,
    output logic                        o_was_replaced,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pli_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int W    = pli_pkg::ONE_W;
    localparam int LY_W = pli_pkg::FRAC_BITS + 8;
    localparam logic [24:0] RECIP_255 = 25'd16843009;

    logic [7:0]  r_thresh, r_bg_red, r_bg_green, r_bg_blue;
    logic [15:0] r_offset;
    logic [pli_pkg::REG_ID_W-1:0] reg_id;
    logic        wr_en;

    pli_pkg::t_front front;
    pli_pkg::t_side  r_side [pli_pkg::DIV_STEPS];
    logic [pli_pkg::DIV_STEPS-1:0] sat_quo, hue_quo;

    logic [LY_W-1:0]    ly, lrem;
    logic [LY_W+24:0]   lprod;
    logic [W-1:0]       lq0, light;
    logic [pli_pkg::OFS_W-1:0] ofs_wide;
    logic [W:0]         nl_sum;
    logic [W-1:0]       new_light;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign reg_id = paddr[pli_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= pli_pkg::RST_THRESH;
            r_bg_red   <= pli_pkg::RST_BG;
            r_bg_green <= pli_pkg::RST_BG;
            r_bg_blue  <= pli_pkg::RST_BG;
            r_offset   <= pli_pkg::RST_OFFSET;
        end else if (wr_en) begin
            case (reg_id)
                pli_pkg::REG_THRESH: r_thresh   <= pwdata[7:0];
                pli_pkg::REG_BG_RED: r_bg_red   <= pwdata[7:0];
                pli_pkg::REG_BG_GRN: r_bg_green <= pwdata[7:0];
                pli_pkg::REG_BG_BLU: r_bg_blue  <= pwdata[7:0];
                pli_pkg::REG_OFFSET: r_offset   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back registers
    always_comb begin
        case (reg_id)
            pli_pkg::REG_THRESH: prdata = {24'd0, r_thresh};
            pli_pkg::REG_BG_RED: prdata = {24'd0, r_bg_red};
            pli_pkg::REG_BG_GRN: prdata = {24'd0, r_bg_green};
            pli_pkg::REG_BG_BLU: prdata = {24'd0, r_bg_blue};
            pli_pkg::REG_OFFSET: prdata = {16'd0, r_offset};
            default:             prdata = 32'd0;
        endcase
    end

    pli_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_red    (i_pixel_red),
        .i_green  (i_pixel_green),
        .i_blue   (i_pixel_blue),
        .i_alpha  (i_pixel_alpha),
        .i_thresh (r_thresh),
        .o_front  (front)
    );

    pli_div u_sat_div (
        .i_clk (i_clk),
        .i_rem (front.s_rem),
        .i_lsb (front.s_lsb),
        .i_den (front.s_den),
        .o_quo (sat_quo)
    );

    pli_div u_hue_div (
        .i_clk (i_clk),
        .i_rem (front.h_rem),
        .i_lsb (front.h_lsb),
        .i_den (front.h_den),
        .o_quo (hue_quo)
    );

    // Lightness = sum * ONE / 510: reciprocal multiply, then one correction
    always_comb begin
        ly    = {front.sum, {(pli_pkg::FRAC_BITS-1){1'b0}}};
        lprod = ly * RECIP_255;
        lq0   = lprod[32 +: W];
        lrem  = ly - (LY_W'({lq0, 8'd0}) - LY_W'(lq0));
        light = (lrem >= LY_W'(255)) ? (lq0 + W'(1)) : lq0;
    end

    // New lightness = min(ONE, offset + ONE - L)
    always_comb begin
        ofs_wide  = (pli_pkg::OFS_W'(r_offset) << pli_pkg::OFS_UP) >> pli_pkg::OFS_DN;
        nl_sum    = {2'b0, ofs_wide[pli_pkg::FRAC_BITS-1:0]} + {1'b0, pli_pkg::ONE}
                    - {1'b0, r_side[0].light};
        new_light = (nl_sum > {1'b0, pli_pkg::ONE}) ? pli_pkg::ONE : nl_sum[W-1:0];
    end

    // Advance sideband beside the dividers; lightness is inverted in the second slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < pli_pkg::DIV_STEPS; j++) r_side[j].valid <= 1'b0;
        end else begin
            r_side[0].valid <= front.valid;
            for (int j = 1; j < pli_pkg::DIV_STEPS; j++) r_side[j].valid <= r_side[j-1].valid;
        end
        r_side[0].replaced <= front.replaced;
        r_side[0].gray     <= front.gray;
        r_side[0].alpha    <= front.alpha;
        r_side[0].light    <= light;
        r_side[1].replaced <= r_side[0].replaced;
        r_side[1].gray     <= r_side[0].gray;
        r_side[1].alpha    <= r_side[0].alpha;
        r_side[1].light    <= new_light;
        for (int j = 2; j < pli_pkg::DIV_STEPS; j++) begin
            r_side[j].replaced <= r_side[j-1].replaced;
            r_side[j].gray     <= r_side[j-1].gray;
            r_side[j].alpha    <= r_side[j-1].alpha;
            r_side[j].light    <= r_side[j-1].light;
        end
    end

    pli_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_side     (r_side[pli_pkg::DIV_STEPS-1]),
        .i_sat      (sat_quo[W-1:0]),
        .i_hue      (hue_quo[pli_pkg::FRAC_BITS-1:0]),
        .i_bg_red   (r_bg_red),
        .i_bg_green (r_bg_green),
        .i_bg_blue  (r_bg_blue),
        .o_valid    (o_valid),
        .o_red      (o_new_red),
        .o_green    (o_new_green),
        .o_blue     (o_new_blue),
        .o_alpha    (o_new_alpha),
        .o_replaced (o_was_replaced)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(pli_pkg::LATENCY) o_valid)
        else $error("request did not produce a result at the pipeline latency");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, pli_pkg::LATENCY))
        else $error("result strobe without a matching request");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_new_alpha == $past(i_pixel_alpha, pli_pkg::LATENCY)))
        else $error("alpha byte not carried with its pixel");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule
